>>> src/assert_macros.svh
// Assertion macros used by the RTL of the scheduler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CHK_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CHK_NOW(lbl, ante, cons)
`define CHK_NEXT(lbl, ante, cons)
`endif
`endif

>>> src/wlts_pkg.sv
// Types and constants of the wavefront layer task scheduler.
package wlts_pkg;

  localparam int MAX_LAYERS = 16;
  localparam int STEP_BITS  = 16;
  localparam int LAYER_BITS = $clog2(MAX_LAYERS);
  localparam int TREE_SIZE  = 1 << LAYER_BITS;
  localparam int NL_BITS    = 5;
  localparam int PRIO_BITS  = 17;
  localparam int ADDR_BITS  = 4;
  localparam int DATA_BITS  = 32;

  localparam logic [STEP_BITS-1:0] STEP_MAX = {STEP_BITS{1'b1}};

  localparam logic [1:0] REG_NUM_LAYERS     = 2'd0;
  localparam logic [1:0] REG_SEQ_LENGTH     = 2'd1;
  localparam logic [1:0] REG_FINAL_PRIORITY = 2'd2;

  typedef enum logic [1:0] {
    ACT_START    = 2'd0,
    ACT_FETCH    = 2'd1,
    ACT_COMPLETE = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_TASK     = 2'd0,
    ST_NONE     = 2'd1,
    ST_FINISHED = 2'd2,
    ST_STARTED  = 2'd3
  } status_t;

  typedef struct packed {
    action_t         action;
    logic [3:0]      layer;
  } cmd_t;

  typedef struct packed {
    status_t         status;
    logic [3:0]      task_layer;
    logic [15:0]     task_step;
  } result_t;

endpackage

>>> src/wavefront_layer_task_scheduler.sv
// Wavefront layer task scheduler: progress counts, pending set and result register.
// Usage: software programs num_layers, seq_length and final_priority over the
// APB port (byte addresses 0, 4 and 8) while no command is in flight, then
// issues commands. A command transfer happens at a rising edge with start high
// and busy low; cmd carries the action and, for a completion, the layer.
// Every command produces exactly one result: result_valid is high for one
// cycle with the result fields, starting at the clock edge after the command
// transfer (the transfer edge loads the command register, the next edge the
// result register).
// A new command may be transferred in every cycle, so the throughput is one
// command per cycle; the combinational path from the command register holds a
// four-level minimum tree over the sixteen pending slots plus the counter
// updates of the completed layer.
// The receiver cannot stall: a result is valid for one cycle only.
// Reset is synchronous and active high. It clears the run state and sets
// num_layers and seq_length to one and final_priority to zero. busy is high
// for the cycle after reset and low from then on.
`include "assert_macros.svh"

module wavefront_layer_task_scheduler (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  wlts_pkg::cmd_t                         cmd,
  output logic                                   result_valid,
  output wlts_pkg::result_t                      result,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [wlts_pkg::ADDR_BITS-1:0]         paddr,
  input  logic [wlts_pkg::DATA_BITS-1:0]         pwdata,
  output logic [wlts_pkg::DATA_BITS-1:0]         prdata,
  output logic                                   pready
);

  logic [wlts_pkg::NL_BITS-1:0]   num_layers;
  logic [wlts_pkg::STEP_BITS-1:0] seq_length;
  logic [wlts_pkg::PRIO_BITS-1:0] final_priority;

  logic           stage_valid;
  wlts_pkg::cmd_t stage_cmd;
  logic           start_staged;

  logic [wlts_pkg::STEP_BITS-1:0] layer_progress [wlts_pkg::MAX_LAYERS];
  logic [wlts_pkg::STEP_BITS-1:0] layer_progress_next [wlts_pkg::MAX_LAYERS];
  logic [wlts_pkg::MAX_LAYERS-1:0] pending_valid;
  logic [wlts_pkg::MAX_LAYERS-1:0] pending_valid_next;
  logic [wlts_pkg::PRIO_BITS-1:0] pending_priority [wlts_pkg::MAX_LAYERS];
  logic [wlts_pkg::PRIO_BITS-1:0] pending_priority_next [wlts_pkg::MAX_LAYERS];
  logic done_flag;
  logic done_flag_next;
  wlts_pkg::result_t result_next;

  logic cfg_write;
  logic cmd_take;

  logic                            tree_valid [wlts_pkg::LAYER_BITS+1][wlts_pkg::TREE_SIZE];
  logic [wlts_pkg::PRIO_BITS-1:0]  tree_prio  [wlts_pkg::LAYER_BITS+1][wlts_pkg::TREE_SIZE];
  logic [wlts_pkg::LAYER_BITS-1:0] tree_idx   [wlts_pkg::LAYER_BITS+1][wlts_pkg::TREE_SIZE];
  logic                            best_found;
  logic [wlts_pkg::LAYER_BITS-1:0] best_idx;
  logic [wlts_pkg::PRIO_BITS-1:0]  best_prio;

  logic [wlts_pkg::NL_BITS-1:0]    nl;
  logic [3:0]                      lay;
  logic                            lay_ok;
  logic [wlts_pkg::NL_BITS-1:0]    nxt_wide;
  logic [3:0]                      nxt_idx;
  logic [wlts_pkg::STEP_BITS-1:0]  prog_lay;
  logic [wlts_pkg::STEP_BITS-1:0]  p_old;
  logic [wlts_pkg::STEP_BITS-1:0]  pn;
  logic [wlts_pkg::STEP_BITS-1:0]  below;
  logic                            next_ok;
  logic                            self_ok;
  logic [wlts_pkg::PRIO_BITS-1:0]  prio_next;
  logic [wlts_pkg::PRIO_BITS-1:0]  prio_self;

  assign pready       = 1'b1;
  assign cfg_write    = psel & penable & pwrite & pready;
  assign cmd_take     = start & ~busy;
  assign start_staged = stage_valid && (stage_cmd.action == wlts_pkg::ACT_START);

  always_comb begin
    unique case (paddr[3:2])
      wlts_pkg::REG_NUM_LAYERS:     prdata = wlts_pkg::DATA_BITS'(num_layers);
      wlts_pkg::REG_SEQ_LENGTH:     prdata = wlts_pkg::DATA_BITS'(seq_length);
      wlts_pkg::REG_FINAL_PRIORITY: prdata = wlts_pkg::DATA_BITS'(final_priority);
      default:                      prdata = '0;
    endcase
  end

  // Minimum tree over the pending slots; ties keep the lower layer.
  always_comb begin
    for (int i = 0; i < wlts_pkg::TREE_SIZE; i++) begin
      if (i < wlts_pkg::MAX_LAYERS) begin
        tree_valid[0][i] = pending_valid[i];
        tree_prio[0][i]  = pending_priority[i];
      end else begin
        tree_valid[0][i] = 1'b0;
        tree_prio[0][i]  = '0;
      end
      tree_idx[0][i] = wlts_pkg::LAYER_BITS'(i);
    end
    for (int l = 1; l <= wlts_pkg::LAYER_BITS; l++) begin
      for (int i = 0; i < wlts_pkg::TREE_SIZE; i++) begin
        tree_valid[l][i] = 1'b0;
        tree_prio[l][i]  = '0;
        tree_idx[l][i]   = '0;
      end
      for (int i = 0; i < wlts_pkg::TREE_SIZE / 2; i++) begin
        if (i < (wlts_pkg::TREE_SIZE >> l)) begin
          if (tree_valid[l-1][2*i+1] &&
              (!tree_valid[l-1][2*i] || tree_prio[l-1][2*i+1] < tree_prio[l-1][2*i])) begin
            tree_valid[l][i] = 1'b1;
            tree_prio[l][i]  = tree_prio[l-1][2*i+1];
            tree_idx[l][i]   = tree_idx[l-1][2*i+1];
          end else begin
            tree_valid[l][i] = tree_valid[l-1][2*i];
            tree_prio[l][i]  = tree_prio[l-1][2*i];
            tree_idx[l][i]   = tree_idx[l-1][2*i];
          end
        end
      end
    end
    best_found = tree_valid[wlts_pkg::LAYER_BITS][0];
    best_prio  = tree_prio[wlts_pkg::LAYER_BITS][0];
    best_idx   = tree_idx[wlts_pkg::LAYER_BITS][0];
  end

  always_comb begin
    nl = (num_layers > wlts_pkg::NL_BITS'(wlts_pkg::MAX_LAYERS)) ?
         wlts_pkg::NL_BITS'(wlts_pkg::MAX_LAYERS) : num_layers;
    lay      = stage_cmd.layer;
    lay_ok   = {1'b0, lay} < nl;
    nxt_wide = {1'b0, lay} + 5'd1;
    nxt_idx  = lay + 4'd1;
    prog_lay = layer_progress[lay];
    p_old    = (prog_lay == wlts_pkg::STEP_MAX) ? prog_lay : prog_lay + 1'b1;
    pn       = layer_progress[nxt_idx];
    below    = (lay == 4'd0) ? seq_length : layer_progress[lay - 4'd1];
    next_ok  = (nxt_wide < nl) && (({1'b0, pn} + 1'b1) >= {1'b0, p_old});
    self_ok  = (p_old < seq_length) && ({1'b0, below} >= ({1'b0, p_old} + 1'b1));
    prio_next = wlts_pkg::PRIO_BITS'(nxt_wide) + wlts_pkg::PRIO_BITS'(pn);
    prio_self = wlts_pkg::PRIO_BITS'(lay) + wlts_pkg::PRIO_BITS'(p_old);
  end

  always_comb begin
    layer_progress_next   = layer_progress;
    pending_valid_next    = pending_valid;
    pending_priority_next = pending_priority;
    done_flag_next        = done_flag;
    result_next.status     = wlts_pkg::ST_NONE;
    result_next.task_layer = '0;
    result_next.task_step  = '0;
    if (stage_valid) begin
      unique case (stage_cmd.action)
        wlts_pkg::ACT_START: begin
          for (int i = 0; i < wlts_pkg::MAX_LAYERS; i++) begin
            layer_progress_next[i] = '0;
          end
          pending_valid_next       = '0;
          pending_valid_next[0]    = 1'b1;
          pending_priority_next[0] = '0;
          done_flag_next           = 1'b0;
          result_next.status       = wlts_pkg::ST_STARTED;
        end
        wlts_pkg::ACT_FETCH: begin
          if (done_flag) begin
            result_next.status = wlts_pkg::ST_FINISHED;
          end else if (best_found) begin
            pending_valid_next[best_idx] = 1'b0;
            if (best_prio >= final_priority) begin
              done_flag_next = 1'b1;
            end
            result_next.status     = wlts_pkg::ST_TASK;
            result_next.task_layer = 4'(best_idx);
            result_next.task_step  = layer_progress[best_idx];
          end
        end
        wlts_pkg::ACT_COMPLETE: begin
          if (lay_ok) begin
            layer_progress_next[lay] = p_old;
            if (next_ok) begin
              if (prio_next >= final_priority) begin
                done_flag_next = 1'b1;
              end
              result_next.status     = wlts_pkg::ST_TASK;
              result_next.task_layer = nxt_idx;
              result_next.task_step  = pn;
              if (self_ok) begin
                pending_valid_next[lay]    = 1'b1;
                pending_priority_next[lay] = prio_self;
              end
            end else if (self_ok) begin
              if (prio_self >= final_priority) begin
                done_flag_next = 1'b1;
              end
              result_next.status     = wlts_pkg::ST_TASK;
              result_next.task_layer = lay;
              result_next.task_step  = p_old;
            end
          end
        end
        default: begin
          result_next.status = wlts_pkg::ST_NONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy           <= 1'b1;
      stage_valid    <= 1'b0;
      result_valid   <= 1'b0;
      num_layers     <= 5'd1;
      seq_length     <= 16'd1;
      final_priority <= '0;
      pending_valid  <= '0;
      done_flag      <= 1'b0;
      for (int i = 0; i < wlts_pkg::MAX_LAYERS; i++) begin
        layer_progress[i] <= '0;
      end
    end else begin
      busy           <= 1'b0;
      stage_valid    <= cmd_take;
      result_valid   <= stage_valid;
      pending_valid  <= pending_valid_next;
      done_flag      <= done_flag_next;
      layer_progress <= layer_progress_next;
      if (cfg_write) begin
        unique case (paddr[3:2])
          wlts_pkg::REG_NUM_LAYERS:     num_layers     <= pwdata[wlts_pkg::NL_BITS-1:0];
          wlts_pkg::REG_SEQ_LENGTH:     seq_length     <= pwdata[wlts_pkg::STEP_BITS-1:0];
          wlts_pkg::REG_FINAL_PRIORITY: final_priority <= pwdata[wlts_pkg::PRIO_BITS-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    stage_cmd        <= cmd;
    pending_priority <= pending_priority_next;
    result           <= result_next;
  end

  `CHK_NEXT(a_result_follows, stage_valid, result_valid)
  `CHK_NEXT(a_no_stray_result, !stage_valid, !result_valid)
  `CHK_NEXT(a_start_clears, start_staged, !done_flag && pending_valid == wlts_pkg::MAX_LAYERS'(1))
  `CHK_NOW(a_done_sticky, $fell(done_flag), $past(start_staged))

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench that drives scheduler commands and scores every result.
module tb;

  localparam int QUIET_LIMIT = 4000;
  localparam logic [1:0] ACT_RESERVED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  wlts_pkg::cmd_t cmd = '0;
  logic result_valid;
  wlts_pkg::result_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [wlts_pkg::ADDR_BITS-1:0] paddr = '0;
  logic [wlts_pkg::DATA_BITS-1:0] pwdata = '0;
  logic [wlts_pkg::DATA_BITS-1:0] prdata;
  logic pready;

  logic [wlts_pkg::NL_BITS-1:0] cfg_layers = 5'd1;
  logic [wlts_pkg::STEP_BITS-1:0] cfg_length = 16'd1;
  logic [wlts_pkg::PRIO_BITS-1:0] cfg_final = '0;
  logic [wlts_pkg::STEP_BITS-1:0] progress [wlts_pkg::MAX_LAYERS];
  logic pend_valid [wlts_pkg::MAX_LAYERS];
  logic [wlts_pkg::PRIO_BITS-1:0] pend_prio [wlts_pkg::MAX_LAYERS];
  logic run_done;

  wlts_pkg::cmd_t queued_cmds [$];
  wlts_pkg::cmd_t staged_cmds [$];
  wlts_pkg::result_t awaited_replies [$];
  wlts_pkg::result_t oldest_reply;
  int idle_pct = 37;
  int mismatches = 0;
  int quiet_cycles = 0;

  wire cmd_xfer = start && !busy;

  wavefront_layer_task_scheduler dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .result_valid(result_valid),
    .result(result),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void clear_grid();
    for (int i = 0; i < wlts_pkg::MAX_LAYERS; i++) begin
      progress[i] = '0;
      pend_valid[i] = 1'b0;
      pend_prio[i] = '0;
    end
    run_done = 1'b0;
  endfunction

  function automatic wlts_pkg::result_t schedule(wlts_pkg::cmd_t c);
    wlts_pkg::result_t r;
    int nl, lay, p_old, pn, below, best, hand;
    r = '0;
    r.status = wlts_pkg::ST_NONE;
    hand = -1;
    best = -1;
    nl = (cfg_layers > wlts_pkg::MAX_LAYERS) ? wlts_pkg::MAX_LAYERS : int'(cfg_layers);
    lay = c.layer;
    case (c.action)
      wlts_pkg::ACT_START: begin
        clear_grid();
        pend_valid[0] = 1'b1;
        r.status = wlts_pkg::ST_STARTED;
      end
      wlts_pkg::ACT_FETCH: begin
        if (run_done) begin
          r.status = wlts_pkg::ST_FINISHED;
        end else begin
          for (int i = 0; i < wlts_pkg::MAX_LAYERS; i++)
            if (pend_valid[i] && (best < 0 || pend_prio[i] < pend_prio[best])) best = i;
          if (best >= 0) begin
            pend_valid[best] = 1'b0;
            if (pend_prio[best] >= cfg_final) run_done = 1'b1;
            hand = best;
          end
        end
      end
      wlts_pkg::ACT_COMPLETE: begin
        if (lay < nl) begin
          if (progress[lay] != wlts_pkg::STEP_MAX) progress[lay] = progress[lay] + 1'b1;
          p_old = progress[lay];
          if (lay + 1 < nl) begin
            pn = progress[lay + 1];
            if (pn + 1 >= p_old) begin
              hand = lay + 1;
              if (lay + 1 + pn >= cfg_final) run_done = 1'b1;
            end
          end
          if (p_old < cfg_length) begin
            below = (lay == 0) ? int'(cfg_length) : int'(progress[lay - 1]);
            if (below >= p_old + 1) begin
              if (hand < 0) begin
                hand = lay;
                if (lay + p_old >= cfg_final) run_done = 1'b1;
              end else begin
                pend_valid[lay] = 1'b1;
                pend_prio[lay] = wlts_pkg::PRIO_BITS'(lay + p_old);
              end
            end
          end
        end
      end
      default: ;
    endcase
    if (hand >= 0) begin
      r.status = wlts_pkg::ST_TASK;
      r.task_layer = hand[3:0];
      r.task_step = progress[hand];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (cmd_xfer) queued_cmds.delete(0);
      if (!start || cmd_xfer) begin
        if (queued_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
          start <= 1'b1;
          cmd <= queued_cmds[0];
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      clear_grid();
    end else begin
      if (result_valid) begin
        if (awaited_replies.size() == 0) begin
          $error("result with no command outstanding: status %0d", result.status);
          mismatches++;
        end else begin
          oldest_reply = awaited_replies.pop_front();
          if (result.status !== oldest_reply.status) begin
            $error("status: expected %0d, got %0d", oldest_reply.status, result.status);
            mismatches++;
          end
          if (result.task_layer !== oldest_reply.task_layer) begin
            $error("task_layer: expected %0d, got %0d", oldest_reply.task_layer,
                   result.task_layer);
            mismatches++;
          end
          if (result.task_step !== oldest_reply.task_step) begin
            $error("task_step: expected %0d, got %0d", oldest_reply.task_step,
                   result.task_step);
            mismatches++;
          end
        end
      end
      if (cmd_xfer) awaited_replies.insert(awaited_replies.size(), schedule(cmd));
    end
  end

  always @(posedge clk) begin
    if (rst || cmd_xfer || result_valid || psel) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("wavefront_layer_task_scheduler: mismatch");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input int value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      wlts_pkg::REG_NUM_LAYERS: cfg_layers = value[wlts_pkg::NL_BITS-1:0];
      wlts_pkg::REG_SEQ_LENGTH: cfg_length = value[wlts_pkg::STEP_BITS-1:0];
      wlts_pkg::REG_FINAL_PRIORITY: cfg_final = value[wlts_pkg::PRIO_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input int layers, input int length, input int fin);
    write_reg(wlts_pkg::REG_NUM_LAYERS, layers);
    write_reg(wlts_pkg::REG_SEQ_LENGTH, length);
    write_reg(wlts_pkg::REG_FINAL_PRIORITY, fin);
  endtask

  function automatic void stage(wlts_pkg::action_t act, int lay);
    wlts_pkg::cmd_t c;
    c.action = act;
    c.layer = lay[3:0];
    staged_cmds.insert(staged_cmds.size(), c);
  endfunction

  // Completions follow the diagonal wavefront order so that runs can reach the
  // finished state; fetches and random, partly malformed commands are mixed in at random.
  function automatic void plan_wavefront(int budget);
    int nl, s;
    nl = (cfg_layers > wlts_pkg::MAX_LAYERS) ? wlts_pkg::MAX_LAYERS : int'(cfg_layers);
    while (staged_cmds.size() < budget) begin
      stage(wlts_pkg::ACT_START, $urandom_range(0, 15));
      for (int d = 0; d <= nl + cfg_length - 2 && staged_cmds.size() < budget; d++)
        for (int l = 0; l < nl; l++) begin
          s = d - l;
          if (s >= 0 && s < cfg_length && staged_cmds.size() < budget) begin
            while ($urandom_range(99) < 45) stage(wlts_pkg::ACT_FETCH, $urandom_range(0, 15));
            if ($urandom_range(99) < 8)
              stage(wlts_pkg::action_t'($urandom_range(wlts_pkg::ACT_FETCH, ACT_RESERVED)),
                    $urandom_range(0, 15));
            stage(wlts_pkg::ACT_COMPLETE, l);
          end
        end
      repeat ($urandom_range(1, 4)) stage(wlts_pkg::ACT_FETCH, $urandom_range(0, 15));
    end
  endfunction

  task automatic drain();
    while (queued_cmds.size() != 0 || awaited_replies.size() != 0) @(negedge clk);
  endtask

  task automatic issue_staged(input bit pause_midway);
    @(negedge clk);
    foreach (staged_cmds[i]) begin
      if (pause_midway && i == staged_cmds.size() / 2) drain();
      queued_cmds.insert(queued_cmds.size(), staged_cmds[i]);
    end
    staged_cmds.delete();
    drain();
  endtask

  task automatic run_phase(input int layers, input int length, input int fin,
                           input int budget, input int idle, input bit pause_midway);
    set_regs(layers, length, fin);
    idle_pct = idle;
    plan_wavefront(budget);
    issue_staged(pause_midway);
  endtask

  initial begin
    int nl_pick, len_pick;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    stage(wlts_pkg::ACT_FETCH, 0);
    stage(wlts_pkg::ACT_COMPLETE, 0);
    stage(wlts_pkg::action_t'(ACT_RESERVED), 15);
    stage(wlts_pkg::ACT_START, 0);
    stage(wlts_pkg::ACT_FETCH, 15);
    stage(wlts_pkg::ACT_FETCH, 0);
    stage(wlts_pkg::ACT_COMPLETE, 15);
    issue_staged(1'b0);

    set_regs(16, 3, 17);
    stage(wlts_pkg::ACT_START, 0);
    stage(wlts_pkg::ACT_FETCH, 0);
    stage(wlts_pkg::ACT_COMPLETE, 0);
    stage(wlts_pkg::ACT_COMPLETE, 1);
    stage(wlts_pkg::ACT_FETCH, 0);
    stage(wlts_pkg::ACT_COMPLETE, 0);
    stage(wlts_pkg::ACT_COMPLETE, 15);
    stage(wlts_pkg::action_t'(ACT_RESERVED), 0);
    stage(wlts_pkg::ACT_COMPLETE, 14);
    stage(wlts_pkg::ACT_FETCH, 10);
    stage(wlts_pkg::ACT_FETCH, 5);
    issue_staged(1'b0);

    run_phase(2, 4, 4, 60, 37, 1'b0);
    run_phase(1, 5, 4, 45, 37, 1'b0);
    run_phase(3, 3, 4, 60, 0, 1'b0);
    run_phase(16, 2, 16, 80, 37, 1'b0);
    run_phase(4, 6, 8, 70, 37, 1'b1);
    run_phase(16, 65535, 65549, 60, 37, 1'b0);
    run_phase(2, 3, 0, 40, 37, 1'b0);
    repeat (3) begin
      nl_pick = $urandom_range(1, 5);
      len_pick = $urandom_range(1, 8);
      run_phase(nl_pick, len_pick, nl_pick + len_pick - 2, 45, 37, 1'b0);
    end

    drain();
    repeat (8) @(negedge clk);
    if (mismatches == 0) $display("wavefront_layer_task_scheduler: match");
    else $display("wavefront_layer_task_scheduler: mismatch");
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/wlts_pkg.sv
src/wavefront_layer_task_scheduler.sv
tb/tb.sv
